// ===== src/pce_pkg.sv =====
// ----------------------------------------------------------------------------
// pce_pkg
// shared types, constants and puncture tables of the punctured conv encoder
// ----------------------------------------------------------------------------
package pce_pkg;

  // code rate register codes
  localparam logic [2:0] RATE_1_2 = 3'd0;
  localparam logic [2:0] RATE_2_3 = 3'd1;
  localparam logic [2:0] RATE_3_4 = 3'd2;
  localparam logic [2:0] RATE_5_6 = 3'd3;
  localparam logic [2:0] RATE_7_8 = 3'd4;

  localparam int NUM_RATES  = 5;
  localparam int CODED_BITS = 16;          // x,y per data bit
  localparam int KEPT_MAX   = CODED_BITS + 1;
  localparam int MAX_PAIRS  = 8;
  localparam int EXT_LEN    = 30;          // longest start offset plus one byte

  localparam int PCE_FIFO_DEPTH = 2;

  // generator taps, g1 = 171 octal, g2 = 133 octal
  localparam logic [6:0] G1_TAPS = 7'h4F;
  localparam logic [6:0] G2_TAPS = 7'h6D;

  localparam logic [3:0]  PAT_LEN  [NUM_RATES] = '{4'd2, 4'd4, 4'd6, 4'd10, 4'd14};
  localparam logic [13:0] PAT_KEEP [NUM_RATES] =
    '{14'h0003, 14'h000B, 14'h001B, 14'h019B, 14'h19AB};

  // pattern unrolled from position zero so a start offset plus j never wraps
  function automatic logic [EXT_LEN-1:0] ext_pattern(input int r);
    logic [EXT_LEN-1:0] res;
    int idx;
    res = '0;
    idx = 0;
    for (int m = 0; m < EXT_LEN; m++) begin
      res[m] = PAT_KEEP[r][idx];
      idx++;
      if (idx == int'(PAT_LEN[r])) idx = 0;
    end
    return res;
  endfunction

  // puncture position after one byte, for every start position
  function automatic logic [15:0][3:0] next_pos_row(input int r);
    logic [15:0][3:0] res;
    int idx;
    for (int p = 0; p < 16; p++) begin
      idx = (p >= int'(PAT_LEN[r])) ? 0 : p;
      for (int s = 0; s < CODED_BITS; s++) begin
        idx++;
        if (idx == int'(PAT_LEN[r])) idx = 0;
      end
      res[p] = 4'(idx);
    end
    return res;
  endfunction

  localparam logic [EXT_LEN-1:0] EXT_PAT [NUM_RATES] =
    '{ext_pattern(0), ext_pattern(1), ext_pattern(2), ext_pattern(3), ext_pattern(4)};

  localparam logic [15:0][3:0] NEXT_POS [NUM_RATES] =
    '{next_pos_row(0), next_pos_row(1), next_pos_row(2), next_pos_row(3),
      next_pos_row(4)};

  // one queued byte worth of pairs
  typedef struct packed {
    logic [MAX_PAIRS-1:0] i_bits;
    logic [MAX_PAIRS-1:0] q_bits;
    logic [3:0]           npairs;
  } pce_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pce_qstat_t;

endpackage

// ===== src/pce_in_if.sv =====
// ----------------------------------------------------------------------------
// pce_in_if
// input byte channel
// ----------------------------------------------------------------------------
interface pce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== src/pce_out_if.sv =====
// ----------------------------------------------------------------------------
// pce_out_if
// coded pair channel
// ----------------------------------------------------------------------------
interface pce_out_if;
  logic valid;
  logic ready;
  logic i_bit;
  logic q_bit;
  logic last_pair;

  modport source (output valid, output i_bit, output q_bit, output last_pair,
                  input ready);
  modport sink   (input valid, input i_bit, input q_bit, input last_pair,
                  output ready);
endinterface

// ===== src/pce_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pce_cfg_if
// code rate register write channel
// ----------------------------------------------------------------------------
interface pce_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] code_rate;

  modport source (output valid, output code_rate, input ready);
  modport sink   (input valid, input code_rate, output ready);
endinterface

// ===== src/pce_front.sv =====
// ----------------------------------------------------------------------------
// pce_front
// byte intake: conv encode, puncture, compact kept bits into pairs
// ----------------------------------------------------------------------------
module pce_front
  import pce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  pce_in_if.sink     in_chan,
  pce_cfg_if.sink    cfg_chan,
  input  pce_qstat_t q_stat,
  output logic       push,
  output pce_entry_t entry
);

  logic [2:0] code_rate_r, code_rate_nxt;
  logic [5:0] hist_r, hist_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic       cv_r, cv_nxt;
  logic       cb_r, cb_nxt;

  logic [2:0]            rate;
  logic [3:0]            len;
  logic [3:0]            eff_pos;
  logic [13:0]           seq;
  logic [6:0]            win;
  logic [CODED_BITS-1:0] coded;
  logic [CODED_BITS-1:0] mask;
  logic [4:0]            ext_idx;
  logic [4:0]            pre [CODED_BITS];
  logic [4:0]            nk;
  logic [KEPT_MAX-1:0]   kept;
  logic                  carry_sel;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !q_stat.full;
  assign push           = in_chan.valid && in_chan.ready;

  always_comb begin
    rate    = (code_rate_r > RATE_7_8) ? RATE_1_2 : code_rate_r;
    len     = PAT_LEN[rate];
    eff_pos = (pos_r >= len) ? 4'd0 : pos_r;
    seq     = {hist_r, in_chan.data_byte};
    coded   = '0;
    mask    = '0;
    win     = '0;
    ext_idx = '0;
    // encoder window for data bit 7-t is seq[13-t:7-t]
    for (int t = 0; t < 8; t++) begin
      win            = seq[13-t -: 7];
      coded[2*t]     = ^(win & G1_TAPS);
      coded[2*t+1]   = ^(win & G2_TAPS);
    end
    for (int j = 0; j < CODED_BITS; j++) begin
      ext_idx = {1'b0, eff_pos} + 5'(j);
      mask[j] = EXT_PAT[rate][ext_idx];
    end
    // slot of each kept bit in the serial stream, carry bit first
    for (int j = 0; j < CODED_BITS; j++) begin
      pre[j] = {4'd0, cv_r} + 5'($countones(mask & ((16'd1 << j) - 16'd1)));
    end
    nk = {4'd0, cv_r} + 5'($countones(mask));
    kept = '0;
    kept[0] = cv_r & cb_r;
    for (int n = 0; n < KEPT_MAX; n++) begin
      for (int j = 0; j < CODED_BITS; j++) begin
        if (mask[j] && (pre[j] == 5'(n))) kept[n] = coded[j];
      end
    end
    // odd leftover sits right after the last full pair
    carry_sel = 1'b0;
    for (int n = 0; n < KEPT_MAX; n++) begin
      if ({nk[4:1], 1'b0} == 5'(n)) carry_sel = kept[n];
    end
    for (int k = 0; k < MAX_PAIRS; k++) begin
      entry.i_bits[k] = kept[2*k];
      entry.q_bits[k] = kept[2*k+1];
    end
    entry.npairs = nk[4:1];
  end

  always_comb begin
    code_rate_nxt = code_rate_r;
    hist_nxt      = hist_r;
    pos_nxt       = pos_r;
    cv_nxt        = cv_r;
    cb_nxt        = cb_r;
    if (push) begin
      hist_nxt = in_chan.data_byte[5:0];
      pos_nxt  = NEXT_POS[rate][eff_pos];
      cv_nxt   = nk[0];
      cb_nxt   = nk[0] & carry_sel;
    end
    if (cfg_chan.valid && cfg_chan.ready) begin
      code_rate_nxt = cfg_chan.code_rate;
      pos_nxt       = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_rate_r <= RATE_1_2;
      hist_r      <= '0;
      pos_r       <= '0;
      cv_r        <= 1'b0;
      cb_r        <= 1'b0;
    end else begin
      code_rate_r <= code_rate_nxt;
      hist_r      <= hist_nxt;
      pos_r       <= pos_nxt;
      cv_r        <= cv_nxt;
      cb_r        <= cb_nxt;
    end
  end

  // puncture position stays inside the active pattern
  a_pos_in_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < len)
    else $error("puncture position outside pattern");

endmodule

// ===== src/pce_fifo.sv =====
// ----------------------------------------------------------------------------
// pce_fifo
// short queue of per-byte pair sets between intake and serializer
// ----------------------------------------------------------------------------
module pce_fifo
  import pce_pkg::*;
#(
  parameter int DEPTH = PCE_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pce_entry_t wr_entry,
  input  logic       pop,
  output pce_entry_t head,
  output pce_qstat_t q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  pce_entry_t    slots [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign head         = slots[rd_ptr_r];
  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    if (push && !pop) count_nxt = count_r + CW'(1);
    if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr_r] <= wr_entry;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.full && !pop) |-> !push)
    else $error("push into full queue");

endmodule

// ===== src/pce_back.sv =====
// ----------------------------------------------------------------------------
// pce_back
// pair serializer, one i/q pair per transaction
// ----------------------------------------------------------------------------
module pce_back
  import pce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  pce_entry_t head,
  input  pce_qstat_t q_stat,
  output logic       pop,
  pce_out_if.source  out_chan
);

  logic [2:0] k_r, k_nxt;
  logic       last;
  logic       xfer;

  assign last               = ({1'b0, k_r} + 4'd1) == head.npairs;
  assign out_chan.valid     = !q_stat.empty;
  assign out_chan.i_bit     = head.i_bits[k_r];
  assign out_chan.q_bit     = head.q_bits[k_r];
  assign out_chan.last_pair = last;
  assign xfer               = out_chan.valid && out_chan.ready;
  assign pop                = xfer && last;

  always_comb begin
    k_nxt = k_r;
    if (xfer) k_nxt = last ? 3'd0 : k_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else begin
      k_r <= k_nxt;
    end
  end

  // pair index never runs past the byte's pair count
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.empty |-> ({1'b0, k_r} < head.npairs))
    else $error("pair index beyond pair count");

  // index restarts after the last pair of a byte
  a_k_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (k_r == 3'd0))
    else $error("pair index not cleared after last pair");

endmodule

// ===== src/punctured_convolutional_encoder.sv =====
// ----------------------------------------------------------------------------
// punctured_convolutional_encoder
// k=7 (171,133) conv encoder with dvb puncturing, bytes in, i/q pairs out
// ----------------------------------------------------------------------------
// a byte's pair set is registered into the queue and offered once it reaches the head
// throughput: one pair per cycle while the output is ready, set by the pair serializer;
//   a byte yields 8 pairs at rate 1/2, down to 4 or 5 at rate 7/8
// reset: synchronous active low; rate 1/2, zero history and position, no carry
// ----------------------------------------------------------------------------
module punctured_convolutional_encoder
  import pce_pkg::*;
#(
  parameter int FIFO_DEPTH = PCE_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  pce_in_if.sink    in_chan,
  pce_cfg_if.sink   cfg_chan,
  pce_out_if.source out_chan
);

  // front to queue
  logic       push;
  pce_entry_t wr_entry;

  // queue to back
  logic       pop;
  pce_entry_t head;
  pce_qstat_t q_stat;

  // front: accepts a byte transaction whenever the queue has room, encodes
  // all 16 coded bits in one go, punctures them and packs the kept bits
  // (with any leftover bit from the previous byte) into up to eight pairs
  pce_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_stat   (q_stat),
    .push     (push),
    .entry    (wr_entry)
  );

  // queue: holds packed pair sets so intake runs ahead of a stalled output
  pce_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // back: walks the head entry one pair per output transaction, flags the
  // last pair of the byte and frees the entry on it
  pce_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
